/* src/rafce_pkg.sv */
// Shared types, codes and constants of the AVI movi frame extractor.
package rafce_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned RES_FIFO_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CHUNK_ID  = 2'd1;

	localparam logic [31:0] MAX_FRAME_BYTES_RST = 32'd5242880;   // 5 MiB
	localparam logic [31:0] FRAME_CHUNK_ID_RST  = 32'h6364_3030; // "00dc"

	// four-character codes, first character in the low byte
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_AVI  = 32'h2049_5641;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_MOVI = 32'h6976_6F6D;

	typedef enum logic [2:0] {
		K_FRAME_BYTE  = 3'd0,
		K_EMPTY_FRAME = 3'd1,
		K_BAD_HEADER  = 3'd2,
		K_MOVI_FOUND  = 3'd3,
		K_TOO_LARGE   = 3'd4,
		K_MOVI_END    = 3'd5,
		K_NO_MOVI     = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		PH_HDR            = 4'd0,
		PH_TOP_ID         = 4'd1,
		PH_TOP_SIZE_LIST  = 4'd2,
		PH_TOP_SIZE_OTHER = 4'd3,
		PH_TOP_LTYPE      = 4'd4,
		PH_TOP_SKIP       = 4'd5,
		PH_MOVI_ID        = 4'd6,
		PH_MOVI_SIZE_FRAME = 4'd7,
		PH_MOVI_SIZE_OTHER = 4'd8,
		PH_FRAME          = 4'd9,
		PH_MOVI_SKIP      = 4'd10,
		PH_IDLE           = 4'd11
	} phase_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  payload_byte;
		logic        frame_last;
		logic        last_in_run;
	} result_t;

	// up to two results caused by one byte
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} run_t;

	typedef struct packed {
		logic [31:0] max_frame_bytes;
		logic [31:0] frame_chunk_id;
	} cfg_t;

endpackage

/* src/rafce_if.sv */
// Request channels of the extractor: byte stream, results and configuration writes.
interface rafce_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       final_byte;

	modport source (output valid, data_byte, first_byte, final_byte, input ready);
	modport sink (input valid, data_byte, first_byte, final_byte, output ready);
endinterface

interface rafce_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] result_kind;
	logic [7:0] payload_byte;
	logic       frame_last;
	logic       last_in_run;

	modport source (output valid, result_kind, payload_byte, frame_last, last_in_run,
		input ready);
	modport sink (input valid, result_kind, payload_byte, frame_last, last_in_run,
		output ready);
endinterface

interface rafce_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/rafce_parser.sv */
// Chunk walker: parser state and the per-byte step that yields up to two results.
module rafce_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	input  logic             final_byte,
	input  rafce_pkg::cfg_t  cfg,
	output rafce_pkg::run_t  run
);
	import rafce_pkg::*;

	phase_t      phase_q, ph;
	logic [3:0]  fbc_q, fbc;
	logic [31:0] ws_q, ws;
	logic [31:0] clen_q, clen;
	logic [32:0] bts_q, bts;
	logic [31:0] mbl_q, mbl;
	logic        pad_q, pad;
	logic [31:0] w;
	logic [32:0] padded;
	logic        done_word;
	run_t        rn;

	function automatic run_t put_res(run_t r, logic en, kind_t k, logic [7:0] b, logic fl);
		result_t x;
		x = '{result_kind: k, payload_byte: b, frame_last: fl, last_in_run: 1'b0};
		if (en && r.n != 2'd2) begin
			if (r.n == 2'd0)
				r.r0 = x;
			else
				r.r1 = x;
			r.n = r.n + 2'd1;
		end
		return r;
	endfunction

	always_comb begin
		if (first_byte) begin
			ph   = PH_HDR;
			fbc  = '0;
			ws   = '0;
			clen = '0;
			bts  = '0;
			mbl  = '0;
			pad  = 1'b0;
		end else begin
			ph   = phase_q;
			fbc  = fbc_q;
			ws   = ws_q;
			clen = clen_q;
			bts  = bts_q;
			mbl  = mbl_q;
			pad  = pad_q;
		end
		w         = {data_byte, ws[31:8]};
		done_word = fbc[1:0] == 2'b11;
		padded    = {1'b0, w} + {32'd0, w[0]};
		rn        = '0;

		if (ph inside {[PH_MOVI_ID:PH_MOVI_SKIP]} && mbl != 32'd0)
			mbl = mbl - 32'd1;

		case (ph)
			PH_HDR: begin
				ws = w;
				if ((fbc == 4'd3 && w != TAG_RIFF) || (fbc == 4'd11 && w != TAG_AVI)) begin
					rn = put_res(rn, 1'b1, K_BAD_HEADER, 8'd0, 1'b0);
					ph = PH_IDLE;
				end else if (fbc >= 4'd11) begin
					fbc = '0;
					ph  = PH_TOP_ID;
				end else begin
					fbc = fbc + 4'd1;
				end
			end
			PH_TOP_ID, PH_MOVI_ID: begin
				ws = w;
				if (done_word) begin
					fbc = '0;
					if (ph == PH_TOP_ID)
						ph = (w == TAG_LIST) ? PH_TOP_SIZE_LIST : PH_TOP_SIZE_OTHER;
					else
						ph = (w == cfg.frame_chunk_id) ? PH_MOVI_SIZE_FRAME
							: PH_MOVI_SIZE_OTHER;
				end else begin
					fbc = fbc + 4'd1;
				end
			end
			PH_TOP_SIZE_LIST, PH_TOP_SIZE_OTHER, PH_MOVI_SIZE_FRAME,
			PH_MOVI_SIZE_OTHER: begin
				ws = w;
				if (!done_word) begin
					fbc = fbc + 4'd1;
				end else begin
					fbc  = '0;
					clen = w;
					pad  = w[0];
					case (ph)
						PH_TOP_SIZE_LIST: begin
							ph = PH_TOP_LTYPE;
						end
						PH_TOP_SIZE_OTHER: begin
							bts = padded;
							ph  = (padded == 33'd0) ? PH_TOP_ID : PH_TOP_SKIP;
						end
						PH_MOVI_SIZE_FRAME: begin
							if (w > cfg.max_frame_bytes) begin
								rn = put_res(rn, 1'b1, K_TOO_LARGE, 8'd0, 1'b0);
								ph = PH_IDLE;
							end else if (w == 32'd0) begin
								rn = put_res(rn, 1'b1, K_EMPTY_FRAME, 8'd0, 1'b0);
								rn = put_res(rn, mbl == 32'd0, K_MOVI_END, 8'd0, 1'b0);
								ph = (mbl == 32'd0) ? PH_IDLE : PH_MOVI_ID;
							end else begin
								bts = {1'b0, w};
								ph  = PH_FRAME;
							end
						end
						default: begin
							bts = padded;
							if (padded == 33'd0) begin
								rn = put_res(rn, mbl == 32'd0, K_MOVI_END, 8'd0, 1'b0);
								ph = (mbl == 32'd0) ? PH_IDLE : PH_MOVI_ID;
							end else begin
								ph = PH_MOVI_SKIP;
							end
						end
					endcase
				end
			end
			PH_TOP_LTYPE: begin
				ws = w;
				if (!done_word) begin
					fbc = fbc + 4'd1;
				end else begin
					fbc = '0;
					if (w == TAG_MOVI) begin
						rn  = put_res(rn, 1'b1, K_MOVI_FOUND, 8'd0, 1'b0);
						mbl = (clen >= 32'd4) ? clen - 32'd4 : 32'd0;
						rn  = put_res(rn, mbl == 32'd0, K_MOVI_END, 8'd0, 1'b0);
						ph  = (mbl == 32'd0) ? PH_IDLE : PH_MOVI_ID;
					end else begin
						bts = {1'b0, clen} + {32'd0, pad};
						bts = (bts >= 33'd4) ? bts - 33'd4 : 33'd0;
						ph  = (bts == 33'd0) ? PH_TOP_ID : PH_TOP_SKIP;
					end
				end
			end
			PH_TOP_SKIP: begin
				if (bts != 33'd0)
					bts = bts - 33'd1;
				if (bts == 33'd0)
					ph = PH_TOP_ID;
			end
			PH_FRAME: begin
				if (bts != 33'd0)
					bts = bts - 33'd1;
				rn = put_res(rn, 1'b1, K_FRAME_BYTE, data_byte, bts == 33'd0);
				if (bts == 33'd0) begin
					if (pad) begin
						pad = 1'b0;
						bts = 33'd1;
						ph  = PH_MOVI_SKIP;
					end else begin
						rn = put_res(rn, mbl == 32'd0, K_MOVI_END, 8'd0, 1'b0);
						ph = (mbl == 32'd0) ? PH_IDLE : PH_MOVI_ID;
					end
				end
			end
			PH_MOVI_SKIP: begin
				if (bts != 33'd0)
					bts = bts - 33'd1;
				if (bts == 33'd0) begin
					rn = put_res(rn, mbl == 32'd0, K_MOVI_END, 8'd0, 1'b0);
					ph = (mbl == 32'd0) ? PH_IDLE : PH_MOVI_ID;
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase

		// file end: report what was still missing
		if (final_byte && ph != PH_IDLE) begin
			if (ph == PH_HDR)
				rn = put_res(rn, 1'b1, K_BAD_HEADER, 8'd0, 1'b0);
			else if (ph inside {[PH_TOP_ID:PH_TOP_SKIP]})
				rn = put_res(rn, 1'b1, K_NO_MOVI, 8'd0, 1'b0);
			else
				rn = put_res(rn, 1'b1, K_MOVI_END, 8'd0, 1'b0);
			ph = PH_IDLE;
		end

		rn.r0.last_in_run = rn.n == 2'd1;
		rn.r1.last_in_run = rn.n == 2'd2;
	end

	assign run = rn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			fbc_q   <= '0;
			ws_q    <= '0;
			clen_q  <= '0;
			bts_q   <= '0;
			mbl_q   <= '0;
			pad_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= ph;
			fbc_q   <= fbc;
			ws_q    <= ws;
			clen_q  <= clen;
			bts_q   <= bts;
			mbl_q   <= mbl;
			pad_q   <= pad;
		end
	end

endmodule

/* src/rafce_res_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one.
module rafce_res_fifo #(
	parameter int unsigned DEPTH = rafce_pkg::RES_FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         wr_cnt,
	input  rafce_pkg::result_t wr0,
	input  rafce_pkg::result_t wr1,
	input  logic               pop,
	output rafce_pkg::result_t head,
	output logic               not_empty,
	output logic               room2,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import rafce_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t         mem [DEPTH];
	logic [AW-1:0]   wp_q, rp_q, wp1;
	logic [CW-1:0]   cnt_q;
	logic            do_pop;

	function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wp1       = nxt(wp_q);
	assign not_empty = cnt_q != '0;
	assign do_pop    = pop && not_empty;
	assign head      = mem[rp_q];
	assign room2     = cnt_q <= CW'(DEPTH - 2);
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0)
			mem[wp_q] <= wr0;
		if (wr_cnt == 2'd2)
			mem[wp1] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_cnt == 2'd1)
				wp_q <= wp1;
			else if (wr_cnt == 2'd2)
				wp_q <= nxt(wp1);
			if (do_pop)
				rp_q <= nxt(rp_q);
			cnt_q <= cnt_q + CW'(wr_cnt) - CW'(do_pop);
		end
	end

endmodule

/* src/riff_avi_frame_chunk_extractor_unit.sv */
// Top level of the AVI movi frame extractor: input stage, parser, result queue, registers.
//
// channel  modport  carries                                          request
// stream   sink     data_byte, first_byte, final_byte                one file byte
// result   source   result_kind, payload_byte, frame_last, last_in_run  one result
// cfg      sink     index, data                                      one register write
//
// One byte a cycle while the result queue has room for two; a two-result byte leaves in turn.
// A byte is registered in the input stage, then parsed and queued once the queue has room.
// The result queue (FIFO_DEPTH entries) decouples the sides; input stalls below 2 free.
// arst_n clears the parser, the queue and the input stage, and loads register defaults.
// Config writes are always taken (ready tied high) and should land while idle.
module riff_avi_frame_chunk_extractor_unit #(
	parameter int unsigned FIFO_DEPTH = rafce_pkg::RES_FIFO_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	rafce_in_if.sink   stream,
	rafce_out_if.source result,
	rafce_cfg_if.sink  cfg
);
	import rafce_pkg::*;

	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	// input stage
	logic        s1_valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        final_s1;

	cfg_t        cfg_q;
	run_t        run;
	result_t     head;
	logic        advance;
	logic        room2;
	logic        not_empty;
	logic [CW-1:0] fifo_count;

	assign advance      = s1_valid_s1 && room2;
	assign stream.ready = !s1_valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			s1_valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1  <= stream.data_byte;
			first_s1 <= stream.first_byte;
			final_s1 <= stream.final_byte;
		end
	end

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_bytes <= MAX_FRAME_BYTES_RST;
			cfg_q.frame_chunk_id  <= FRAME_CHUNK_ID_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_FRAME_BYTES: cfg_q.max_frame_bytes <= cfg.data;
				REG_FRAME_CHUNK_ID:  cfg_q.frame_chunk_id  <= cfg.data;
				default: ;
			endcase
		end
	end

	rafce_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.final_byte (final_s1),
		.cfg        (cfg_q),
		.run        (run)
	);

	rafce_res_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cnt    (advance ? run.n : 2'd0),
		.wr0       (run.r0),
		.wr1       (run.r1),
		.pop       (result.ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2),
		.count     (fifo_count)
	);

	assign result.valid        = not_empty;
	assign result.result_kind  = head.result_kind;
	assign result.payload_byte = head.payload_byte;
	assign result.frame_last   = head.frame_last;
	assign result.last_in_run  = head.last_in_run;

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// a held input stage keeps its byte until the queue has room
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !room2 |=> s1_valid_s1 && $stable(data_s1) && $stable(first_s1))
		else $error("input stage lost a stalled byte");

	// only frame bytes carry a payload or a frame end mark
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.result_kind != K_FRAME_BYTE |->
			result.payload_byte == 8'd0 && !result.frame_last)
		else $error("payload on a non-frame result");

endmodule
